### rtl/core/dtc_pkg.sv
// Shared types, register map and saturation helper for the drive/turn controller.
package dtc_pkg;

  localparam int unsigned AddrW = 5;

  typedef enum logic [2:0] {
    RegLinGain   = 3'd0,
    RegHeadGain  = 3'd1,
    RegTurnGain  = 3'd2,
    RegLinLimit  = 3'd3,
    RegLinTol    = 3'd4,
    RegTurnTol   = 3'd5,
    RegSettleMs  = 3'd6
  } dtc_reg_e;

  typedef enum logic {
    ModeStraight = 1'b0,
    ModeTurn     = 1'b1
  } dtc_mode_e;

  typedef struct packed {
    logic signed [31:0] linear_gain;
    logic signed [31:0] heading_gain;
    logic signed [31:0] turn_gain;
    logic [14:0]        linear_limit;
    logic [18:0]        lin_tol;
    logic [16:0]        turn_tolerance;
    logic [15:0]        settle_ms;
  } dtc_cfg_t;

  localparam logic signed [31:0] LinGainRst  = 32'sd10066330;
  localparam logic signed [31:0] HeadGainRst = 32'sd402653;
  localparam logic signed [31:0] TurnGainRst = -32'sd402653;
  localparam logic [14:0]        LinLimitRst = 15'd24576;
  localparam logic [18:0]        LinTolRst   = 19'd13;
  localparam logic [16:0]        TurnTolRst  = 17'd320;
  localparam logic [15:0]        SettleMsRst = 16'd100;

  // products after the >>16, kept at full range
  typedef struct packed {
    dtc_mode_e          mode;
    logic signed [36:0] pa;
    logic signed [33:0] pb;
    logic               done;
  } dtc_prod_t;

  localparam logic signed [15:0] CmdMax = 16'sd32767;

  function automatic logic signed [15:0] sat_cmd(input logic signed [37:0] v);
    logic signed [15:0] r;
    if (v > 38'sd32767) begin
      r = CmdMax;
    end else if (v < -38'sd32767) begin
      r = -CmdMax;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/dtc_req_if.sv
// Request channel: one control tick of sensor data.
interface dtc_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [19:0] target;
  logic signed [19:0] measured_distance;
  logic signed [17:0] heading_angle;
  logic [31:0]        time_now;

  modport source (output valid, req_type, target, measured_distance, heading_angle, time_now,
                  input ready);
  modport sink   (input valid, req_type, target, measured_distance, heading_angle, time_now,
                  output ready);
endinterface

### rtl/core/dtc_res_if.sv
// Result channel: left/right drive commands and the done flag.
interface dtc_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_cmd;
  logic signed [15:0] right_cmd;
  logic               done_res;

  modport source (output valid, left_cmd, right_cmd, done_res, input ready);
  modport sink   (input valid, left_cmd, right_cmd, done_res, output ready);
endinterface

### rtl/core/dtc_regs.sv
// APB-style configuration register file.
module dtc_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [dtc_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output dtc_pkg::dtc_cfg_t         cfg_o
);
  import dtc_pkg::*;

  dtc_cfg_t cfg_q, cfg_d;
  dtc_reg_e idx;
  logic     wr;

  assign idx   = dtc_reg_e'(paddr[AddrW-1:2]);
  assign wr    = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (idx)
        RegLinGain:  cfg_d.linear_gain      = pwdata;
        RegHeadGain: cfg_d.heading_gain     = pwdata;
        RegTurnGain: cfg_d.turn_gain        = pwdata;
        RegLinLimit: cfg_d.linear_limit     = pwdata[14:0];
        RegLinTol:   cfg_d.lin_tol          = pwdata[18:0];
        RegTurnTol:  cfg_d.turn_tolerance   = pwdata[16:0];
        RegSettleMs: cfg_d.settle_ms        = pwdata[15:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegLinGain:  prdata = cfg_q.linear_gain;
      RegHeadGain: prdata = cfg_q.heading_gain;
      RegTurnGain: prdata = cfg_q.turn_gain;
      RegLinLimit: prdata = 32'(cfg_q.linear_limit);
      RegLinTol:   prdata = 32'(cfg_q.lin_tol);
      RegTurnTol:  prdata = 32'(cfg_q.turn_tolerance);
      RegSettleMs: prdata = 32'(cfg_q.settle_ms);
      default:     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.linear_gain      <= LinGainRst;
      cfg_q.heading_gain     <= HeadGainRst;
      cfg_q.turn_gain        <= TurnGainRst;
      cfg_q.linear_limit     <= LinLimitRst;
      cfg_q.lin_tol          <= LinTolRst;
      cfg_q.turn_tolerance   <= TurnTolRst;
      cfg_q.settle_ms        <= SettleMsRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### rtl/core/dtc_mul_stage.sv
// Input register, error/gain multiplies and settle tracking, product register.
module dtc_mul_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  dtc_req_if.sink            req_i,
  input  dtc_pkg::dtc_cfg_t  cfg_i,
  output logic               prod_valid_o,
  input  logic               prod_ready_i,
  output dtc_pkg::dtc_prod_t prod_o
);
  import dtc_pkg::*;

  logic               v1_q, v2_q;
  dtc_mode_e          mode1_q;
  logic signed [19:0] tgt1_q, dist1_q;
  logic signed [17:0] ang1_q;
  logic [31:0]        now1_q;
  dtc_prod_t          prod_q, prod_d;

  logic        settling_q, settling_d;
  logic [31:0] start_q, start_d;

  logic s1_en, s2_en, adv;

  logic signed [20:0] err, ang_x, tgt_x, dist_x;
  logic signed [31:0] gain_a;
  logic signed [52:0] pa_full;
  logic signed [49:0] pb_full;
  logic [20:0]        mag, tol;
  logic [31:0]        elapsed;
  logic               done;

  assign s2_en       = !v2_q || prod_ready_i;
  assign s1_en       = !v1_q || s2_en;
  assign adv         = v1_q && s2_en;
  assign req_i.ready = s1_en;

  assign ang_x  = 21'(ang1_q);
  assign tgt_x  = 21'(tgt1_q);
  assign dist_x = 21'(dist1_q);

  assign err     = (mode1_q == ModeTurn) ? (ang_x - tgt_x) : (dist_x - tgt_x);
  assign gain_a  = (mode1_q == ModeTurn) ? cfg_i.turn_gain : cfg_i.linear_gain;
  assign pa_full = 53'(err) * 53'(gain_a);
  assign pb_full = 50'(ang1_q) * 50'(cfg_i.heading_gain);

  assign mag     = err[20] ? 21'(-err) : 21'(err);
  assign tol     = (mode1_q == ModeTurn) ? 21'(cfg_i.turn_tolerance)
                                         : 21'(cfg_i.lin_tol);
  assign elapsed = now1_q - start_q;

  // tolerance edge: strictly inside to start, strictly outside to drop out
  always_comb begin
    settling_d = settling_q;
    start_d    = start_q;
    done       = 1'b0;
    if (!settling_q) begin
      if (mag < tol) begin
        settling_d = 1'b1;
        start_d    = now1_q;
      end
    end else if (mag > tol) begin
      settling_d = 1'b0;
    end else if (elapsed > 32'(cfg_i.settle_ms)) begin
      settling_d = 1'b0;
      done       = 1'b1;
    end
  end

  always_comb begin
    prod_d.mode = mode1_q;
    prod_d.pa   = pa_full[52:16];
    prod_d.pb   = pb_full[49:16];
    prod_d.done = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      settling_q <= 1'b0;
      start_q    <= 32'd0;
    end else begin
      if (s1_en) begin
        v1_q <= req_i.valid;
      end
      if (s2_en) begin
        v2_q <= v1_q;
      end
      if (adv) begin
        settling_q <= settling_d;
        start_q    <= start_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && req_i.valid) begin
      mode1_q <= dtc_mode_e'(req_i.req_type);
      tgt1_q  <= req_i.target;
      dist1_q <= req_i.measured_distance;
      ang1_q  <= req_i.heading_angle;
      now1_q  <= req_i.time_now;
    end
    if (adv) begin
      prod_q <= prod_d;
    end
  end

  assign prod_valid_o = v2_q;
  assign prod_o       = prod_q;

endmodule

### rtl/core/dtc_out_stage.sv
// Straight mode: clamp and heading mix; both modes: output saturation into the result register.
module dtc_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dtc_pkg::dtc_cfg_t  cfg_i,
  input  logic               prod_valid_i,
  output logic               prod_ready_o,
  input  dtc_pkg::dtc_prod_t prod_i,
  dtc_res_if.source          res_o
);
  import dtc_pkg::*;

  logic               v_q;
  logic signed [15:0] left_q, right_q, left_d, right_d;
  logic               done_q;
  logic               load;

  logic signed [37:0] pa_x, pb_x, lim, lin, sum, dif;

  assign prod_ready_o = !v_q || res_o.ready;
  assign load         = prod_valid_i && prod_ready_o;

  assign pa_x = 38'(prod_i.pa);
  assign pb_x = 38'(prod_i.pb);
  assign lim  = $signed({23'd0, cfg_i.linear_limit});
  assign lin  = (pa_x > lim) ? lim : ((pa_x < -lim) ? -lim : pa_x);
  assign sum  = lin + pb_x;
  assign dif  = lin - pb_x;

  always_comb begin
    if (prod_i.mode == ModeTurn) begin
      left_d  = sat_cmd(-pa_x);
      right_d = sat_cmd(pa_x);
    end else begin
      left_d  = sat_cmd(sum);
      right_d = sat_cmd(dif);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (prod_ready_o) begin
      v_q <= prod_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      left_q  <= left_d;
      right_q <= right_d;
      done_q  <= prod_i.done;
    end
  end

  assign res_o.valid     = v_q;
  assign res_o.left_cmd  = left_q;
  assign res_o.right_cmd = right_q;
  assign res_o.done_res  = done_q;

endmodule

### rtl/core/drive_turn_p_control_settle.sv
// Proportional drive/turn controller with settle detection.
// A request passes through the input, product and result registers in turn.
// Throughput: one request per cycle; each stage holds when its successor is full and stalled.
// Settle state is updated as each request moves from the input to the product register.
// Reset (rst_ni low, async): pipeline empty, settle flag and start time cleared,
// registers at their defaults.
module drive_turn_p_control_settle (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  dtc_req_if.sink                   req_i,
  dtc_res_if.source                 res_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [dtc_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import dtc_pkg::*;

  dtc_cfg_t  cfg;
  dtc_prod_t prod;
  logic      prod_valid, prod_ready;

  dtc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dtc_mul_stage u_mul (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .cfg_i        (cfg),
    .prod_valid_o (prod_valid),
    .prod_ready_i (prod_ready),
    .prod_o       (prod)
  );

  dtc_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .prod_valid_i (prod_valid),
    .prod_ready_o (prod_ready),
    .prod_i       (prod),
    .res_o        (res_o)
  );

endmodule
